@@ design/crc32ws_pkg.sv @@
`timescale 1ns / 1ps

package crc32ws_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned COUNT_W   = 6;

  localparam logic [WORD_BITS-1:0] POLY_RESET = 32'h04C1_1DB7;

  // One accepted request as held in the input register
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } item_t;

  // Counts above one word consume the whole word
  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] raw);
    logic [COUNT_W-1:0] full;
    full = COUNT_W'(WORD_BITS);
    sat_count = (raw > full) ? full : raw;
  endfunction

endpackage

@@ design/crc32ws_bit_step.sv @@
`timescale 1ns / 1ps

module crc32ws_bit_step (
  input  logic [crc32ws_pkg::WORD_BITS-1:0] rem_in,
  input  logic                              data_bit,
  input  logic                              enable,
  input  logic [crc32ws_pkg::WORD_BITS-1:0] poly,
  output logic [crc32ws_pkg::WORD_BITS-1:0] rem_out
);

  logic [crc32ws_pkg::WORD_BITS-1:0] shifted;
  logic [crc32ws_pkg::WORD_BITS-1:0] fold;

  always_comb begin
    shifted = {rem_in[crc32ws_pkg::WORD_BITS-2:0], data_bit};
    // fold in the generator when the old top bit leaves
    fold    = rem_in[crc32ws_pkg::WORD_BITS-1] ? poly : '0;
    rem_out = enable ? (shifted ^ fold) : rem_in;
  end

endmodule

@@ design/crc32ws_absorb.sv @@
`timescale 1ns / 1ps

module crc32ws_absorb (
  input  logic [crc32ws_pkg::WORD_BITS-1:0] rem_in,
  input  logic [crc32ws_pkg::WORD_BITS-1:0] word,
  input  logic [crc32ws_pkg::COUNT_W-1:0]   count,
  input  logic [crc32ws_pkg::WORD_BITS-1:0] poly,
  output logic [crc32ws_pkg::WORD_BITS-1:0] rem_out
);

  logic [crc32ws_pkg::WORD_BITS-1:0] chain [0:crc32ws_pkg::WORD_BITS];

  assign chain[0] = rem_in;

  // one cell per message bit, bit 31 first; cells past the count pass through
  for (genvar k = 0; k < crc32ws_pkg::WORD_BITS; k++) begin : g_step
    localparam logic [crc32ws_pkg::COUNT_W-1:0] STEP = crc32ws_pkg::COUNT_W'(k);

    crc32ws_bit_step u_step (
      .rem_in   (chain[k]),
      .data_bit (word[crc32ws_pkg::WORD_BITS-1-k]),
      .enable   (count > STEP),
      .poly     (poly),
      .rem_out  (chain[k+1])
    );
  end

  assign rem_out = chain[crc32ws_pkg::WORD_BITS];

endmodule

@@ design/crc32_word_stream_check_top.sv @@
`timescale 1ns / 1ps
// A request is registered into the input register when accepted; a last-word request then
// loads crc_value and raises crc_valid once the output register has room for it.
// Throughput: one word per cycle, set by the 32-cell XOR chain that runs from the
// remainder register back into itself; output stalls hold only last-word requests.
// Reset (rst, synchronous): clears the remainder, empties both stages and reloads
// the polynomial with 0x04C11DB7.

module crc32_word_stream_check_top (
  input  logic        clk,
  input  logic        rst,

  input  logic        polynomial_we,
  input  logic [31:0] polynomial_wdata,

  input  logic        data_valid,
  output logic        data_stall,
  input  logic [31:0] data_word,
  input  logic [5:0]  bits_in_word,
  input  logic        last_word,

  output logic        crc_valid,
  input  logic        crc_stall,
  output logic [31:0] crc_value
);

  logic [crc32ws_pkg::WORD_BITS-1:0] polynomial;
  logic [crc32ws_pkg::WORD_BITS-1:0] remainder;
  logic [crc32ws_pkg::WORD_BITS-1:0] remainder_next;
  logic [crc32ws_pkg::WORD_BITS-1:0] absorbed;
  crc32ws_pkg::item_t                item;
  logic                              item_valid;
  logic                              out_free;
  logic                              item_fire;
  logic                              data_take;

  assign out_free   = !crc_valid || !crc_stall;
  // a last-word request waits only for room in the output register
  assign item_fire  = item_valid && (!item.last || out_free);
  assign data_stall = item_valid && !item_fire;
  assign data_take  = data_valid && !data_stall;

  crc32ws_absorb u_absorb (
    .rem_in  (remainder),
    .word    (item.word),
    .count   (item.count),
    .poly    (polynomial),
    .rem_out (absorbed)
  );

  always_comb begin
    remainder_next = remainder;
    if (item_fire) begin
      remainder_next = item.last ? '0 : absorbed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= crc32ws_pkg::POLY_RESET;
    end else if (polynomial_we) begin
      polynomial <= polynomial_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (data_take) begin
      item_valid <= 1'b1;
    end else if (item_fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_take) begin
      item.word  <= data_word;
      item.count <= crc32ws_pkg::sat_count(bits_in_word);
      item.last  <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else begin
      remainder <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_valid <= 1'b0;
    end else if (item_fire && item.last) begin
      crc_valid <= 1'b1;
    end else if (!crc_stall) begin
      crc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.last) begin
      crc_value <= absorbed;
    end
  end

`ifndef SYNTH
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_fire && item.last |=> crc_valid)
    else $error("last-word request did not raise a result");

  a_last_clears_rem: assert property (@(posedge clk) disable iff (rst)
    item_fire && item.last |=> remainder == '0)
    else $error("remainder not cleared after last word");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> item_valid && item.last && crc_valid && crc_stall)
    else $error("input stalled without a blocked last word");

  a_blocked_rem_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.last && crc_valid && crc_stall |=> $stable(remainder))
    else $error("remainder moved while last word was blocked");

  a_idle_rem_hold: assert property (@(posedge clk) disable iff (rst)
    !item_valid |=> $stable(remainder))
    else $error("remainder moved with no request in hand");
`endif

endmodule

@@ tb/crc32_word_stream_check_top_tb.sv @@
`timescale 1ns / 1ps

module crc32_word_stream_check_top_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 64;
  localparam int SETTLE_CYC  = 4;

  // Running CRC of the open message and the checksums still owed by the block
  class crc_scoreboard;
    logic [31:0] poly;
    logic [31:0] rem;
    logic [31:0] crc_due[$];
    int          errors;
    int          words_seen;
    int          crcs_checked;

    function new();
      poly = crc32ws_pkg::POLY_RESET;
      rem = '0;
      errors = 0;
      words_seen = 0;
      crcs_checked = 0;
    endfunction

    function void set_poly(input logic [31:0] p);
      poly = p;
    endfunction

    function void note_word(input logic [31:0] w, input logic [5:0] c, input logic l);
      int          n;
      int          k;
      logic        carry;
      n = (c > crc32ws_pkg::WORD_BITS) ? crc32ws_pkg::WORD_BITS : c;
      for (k = 0; k < n; k++) begin
        carry = rem[31];
        rem = {rem[30:0], w[31-k]};
        if (carry) rem ^= poly;
      end
      words_seen++;
      if (l) begin
        crc_due.push_back(rem);
        rem = '0;
      end
    endfunction

    function void check_crc(input logic [31:0] got);
      logic [31:0] want;
      if (crc_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: crc_value %h with no checksum owed", $realtime, got);
      end else begin
        want = crc_due.pop_front();
        crcs_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("%0t: crc_value wrong: expected %h, got %h", $realtime, want, got);
        end
      end
    endfunction

    function int pending();
      return crc_due.size();
    endfunction

    function void close_out();
      if (crc_due.size() != 0) begin
        errors += crc_due.size();
        $display("%0d checksums never delivered", crc_due.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        polynomial_we = 1'b0;
  logic [31:0] polynomial_wdata = '0;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [31:0] data_word = '0;
  logic [5:0]  bits_in_word = '0;
  logic        last_word = 1'b0;
  logic        crc_valid;
  logic        crc_stall = 1'b0;
  logic [31:0] crc_value;

  crc_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int polys_loaded = 0;

  crc32_word_stream_check_top DUT (
    .clk              (clk),
    .rst              (rst),
    .polynomial_we    (polynomial_we),
    .polynomial_wdata (polynomial_wdata),
    .data_valid       (data_valid),
    .data_stall       (data_stall),
    .data_word        (data_word),
    .bits_in_word     (bits_in_word),
    .last_word        (last_word),
    .crc_valid        (crc_valid),
    .crc_stall        (crc_stall),
    .crc_value        (crc_value)
  );

  always #4 clk = ~clk;

  // Sample both handshakes on the edge that completes them
  always @(posedge clk) begin
    if (!rst && data_valid && !data_stall) sb.note_word(data_word, bits_in_word, last_word);
    if (!rst && crc_valid && !crc_stall) sb.check_crc(crc_value);
  end

  // Receiver: random stalls, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left <= LONG_HOLD;
      crc_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      crc_stall <= 1'b1;
    end else begin
      crc_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (crc_valid && !crc_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("crc32_word_stream_check_top: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 32'h0000_0000;
    else if (r < 16) return 32'hFFFF_FFFF;
    else return $urandom;
  endfunction

  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 6'd32;
    else if (r < 85) return 6'($urandom_range(1, 31));
    else if (r < 92) return 6'd0;
    else return 6'($urandom_range(33, 63));
  endfunction

  task automatic send_word(input logic [31:0] w, input logic [5:0] c, input logic l);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      data_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    data_valid <= 1'b1;
    data_word <= w;
    bits_in_word <= c;
    last_word <= l;
    @(posedge clk);
    while (data_stall) @(posedge clk);
  endtask

  // Hold off new requests until every checksum is in and the pipe has emptied
  task automatic settle();
    data_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_poly(input logic [31:0] p);
    polynomial_we <= 1'b1;
    polynomial_wdata <= p;
    @(posedge clk);
    polynomial_we <= 1'b0;
    sb.set_poly(p);
    polys_loaded++;
  endtask

  task automatic send_messages(input int n_words);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++) send_word(pick_word(), pick_count(), k == len - 1);
      sent += len;
    end
  endtask

  task automatic run_phase(input logic [31:0] p, input int gap, input int stall, input int n);
    settle();
    load_poly(p);
    gap_pct = gap;
    stall_pct <= stall;
    send_messages(n);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_poly(crc32ws_pkg::POLY_RESET);

    send_word(32'h0000_0000, 6'd32, 1'b1);
    send_word(32'hFFFF_FFFF, 6'd32, 1'b1);
    send_word(32'h8000_0000, 6'd1, 1'b1);
    // empty message: nothing absorbed, checksum of zero
    send_word(32'hFFFF_FFFF, 6'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 6'd0, 1'b0);
    send_word(32'h1234_5678, 6'd32, 1'b1);
    // oversized counts take the whole word
    send_word(32'hA5A5_A5A5, 6'd33, 1'b0);
    send_word(32'h5A5A_5A5A, 6'd63, 1'b1);
    send_word(32'hFFFF_FFFF, 6'd31, 1'b0);
    send_word(32'hDEAD_BEEF, 6'd32, 1'b0);
    send_word(32'h0000_0000, 6'd1, 1'b1);
    // zero count on the last word still flushes the open remainder
    send_word(32'h3141_5926, 6'd32, 1'b0);
    send_word(32'hFFFF_FFFF, 6'd0, 1'b1);
    send_word(32'h3132_3334, 6'd32, 1'b0);
    send_word(32'h3536_3738, 6'd32, 1'b0);
    send_word(32'h3900_0000, 6'd8, 1'b1);
    // change the polynomial inside an open message
    send_word(32'hC0FF_EE11, 6'd32, 1'b0);
    settle();
    load_poly(32'h04C1_0DB7);
    send_word(32'hFACE_0000, 6'd16, 1'b1);

    run_phase(32'h04C1_0DB7, 0, 0, 70);
    run_phase(32'h0000_0000, 83, 0, 70);
    run_phase(32'hFFFF_FFFF, 0, 83, 70);
    run_phase(32'h8000_0000, 13, 13, 70);
    run_phase(32'h0000_0001, 0, 0, 30);

    // fill the block behind a long receiver hold-off
    settle();
    gap_pct = 0;
    stall_pct <= 0;
    hold_asks <= hold_asks + 1;
    repeat (20) send_word(pick_word(), 6'd32, 1'b1);
    run_phase($urandom, 0, 0, 40);

    settle();
    repeat (8) @(posedge clk);
    sb.close_out();
    $display("%0d words sent, %0d checksums compared over %0d polynomial loads",
             sb.words_seen, sb.crcs_checked, polys_loaded);
    $display("idling on neither, either and both sides; one long output hold-off");
    if (sb.errors == 0) begin
      $display("crc32_word_stream_check_top: match");
    end else begin
      $display("%0d errors", sb.errors);
      $display("crc32_word_stream_check_top: mismatch");
    end
    $finish;
  end

endmodule
